[src/assert_macros.svh]
// assertion helpers, sampled on clk_i and off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("limiter assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("limiter assertion failed");

`endif

[src/pswl_pkg.sv]
package pswl_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned MaxStamps  = 16;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WinW     = 16;
  localparam int unsigned ReqLimW  = 5;
  localparam int unsigned CliLimW  = 7;
  localparam int unsigned OutcomeW = 3;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic             EnableRst = 1'b1;
  localparam logic [WinW-1:0]  WindowRst = 16'd60;
  localparam logic [ReqLimW-1:0] ReqLimRst = 5'd10;
  localparam logic [CliLimW-1:0] CliLimRst = 7'd64;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_REQ_LIMIT  = 2'd2,
    REG_CLI_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_ALLOWED    = 3'd0,
    OUT_REFUSED    = 3'd1,
    OUT_NEW_ENTRY  = 3'd2,
    OUT_TABLE_FULL = 3'd3,
    OUT_DISABLED   = 3'd4
  } outcome_e;

  typedef struct packed {
    logic               enable;
    logic [WinW-1:0]    window;
    logic [ReqLimW-1:0] req_limit;
    logic [CliLimW-1:0] cli_limit;
  } cfg_t;

  typedef struct packed {
    logic ent_re;
    logic ent_we;
    logic stp_re;
    logic stp_we;
  } mem_ctl_t;

endpackage

[src/pswl_alu.sv]
module pswl_alu (
  input  logic [pswl_pkg::AddrW-1:0] a_i,
  input  logic [pswl_pkg::AddrW-1:0] b_i,
  input  logic [pswl_pkg::WinW-1:0]  window_i,
  output logic                       eq_o,
  output logic                       young_o
);

  logic [pswl_pkg::AddrW-1:0] diff;

  // one subtractor serves both the address match and the stamp age test
  assign diff    = a_i - b_i;
  assign eq_o    = (diff == '0);
  assign young_o = (diff < pswl_pkg::AddrW'(window_i));

endmodule

[src/pswl_store.sv]
module pswl_store #(
  parameter int unsigned MAX_ENTRIES = pswl_pkg::MaxEntries,
  parameter int unsigned MAX_STAMPS  = pswl_pkg::MaxStamps,
  localparam int unsigned EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned SIW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1,
  localparam int unsigned HW  = $clog2(MAX_STAMPS + 1),
  localparam int unsigned EW  = pswl_pkg::AddrW + 2 * HW,
  localparam int unsigned STW = EIW + SIW
) (
  input  logic                 clk_i,
  input  pswl_pkg::mem_ctl_t   mem_ctl_i,
  input  logic [EIW-1:0]       ent_raddr_i,
  input  logic [EIW-1:0]       ent_waddr_i,
  input  logic [EW-1:0]        ent_wdata_i,
  output logic [EW-1:0]        ent_rdata_o,
  input  logic [STW-1:0]       stp_raddr_i,
  input  logic [STW-1:0]       stp_waddr_i,
  input  logic [pswl_pkg::TimeW-1:0] stp_wdata_i,
  output logic [pswl_pkg::TimeW-1:0] stp_rdata_o
);

  localparam int unsigned STDEPTH = MAX_ENTRIES << SIW;

  // entry word: client address, next ring slot, count of slots ever written
  logic [EW-1:0]              ent_mem [MAX_ENTRIES];
  logic [pswl_pkg::TimeW-1:0] stp_mem [STDEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.ent_we) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (mem_ctl_i.ent_re) begin
      ent_rdata_o <= ent_mem[ent_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.stp_we) begin
      stp_mem[stp_waddr_i] <= stp_wdata_i;
    end
    if (mem_ctl_i.stp_re) begin
      stp_rdata_o <= stp_mem[stp_raddr_i];
    end
  end

endmodule

[src/pswl_seq.sv]
`include "assert_macros.svh"

module pswl_seq #(
  parameter int unsigned MAX_ENTRIES = pswl_pkg::MaxEntries,
  parameter int unsigned MAX_STAMPS  = pswl_pkg::MaxStamps,
  localparam int unsigned EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned SIW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1,
  localparam int unsigned HW  = $clog2(MAX_STAMPS + 1),
  localparam int unsigned EW  = pswl_pkg::AddrW + 2 * HW,
  localparam int unsigned STW = EIW + SIW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pswl_pkg::cfg_t             cfg_i,
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [pswl_pkg::AddrW-1:0] client_addr_i,
  input  logic [pswl_pkg::TimeW-1:0] now_seconds_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic                       limited_o,
  output pswl_pkg::outcome_e         outcome_o,
  output pswl_pkg::mem_ctl_t         mem_ctl_o,
  output logic [EIW-1:0]             ent_raddr_o,
  output logic [EIW-1:0]             ent_waddr_o,
  output logic [EW-1:0]              ent_wdata_o,
  input  logic [EW-1:0]              ent_rdata_i,
  output logic [STW-1:0]             stp_raddr_o,
  output logic [STW-1:0]             stp_waddr_o,
  output logic [pswl_pkg::TimeW-1:0] stp_wdata_o,
  input  logic [pswl_pkg::TimeW-1:0] stp_rdata_i,
  output logic [pswl_pkg::AddrW-1:0] alu_a_o,
  output logic [pswl_pkg::AddrW-1:0] alu_b_o,
  input  logic                       alu_eq_i,
  input  logic                       alu_young_i
);

  localparam int unsigned UW  = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COUNT,
    ST_DECIDE,
    ST_CREATE,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic [pswl_pkg::AddrW-1:0] addr_q;
  logic [pswl_pkg::TimeW-1:0] now_q;
  logic [UW-1:0]              ridx_q;
  logic [EIW-1:0]             pidx_q;
  logic                       rv_q;
  logic [EIW-1:0]             hit_idx_q;
  logic [HW-1:0]              slot_q;
  logic [HW-1:0]              hw_q;
  logic [HW-1:0]              cidx_q;
  logic [HW-1:0]              cnt_q;
  logic [UW-1:0]              used_q;
  logic                       res_lim_q;
  pswl_pkg::outcome_e         res_code_q;
  logic                       out_valid_q;
  logic                       out_lim_q;
  pswl_pkg::outcome_e         out_code_q;

  logic [HW-1:0]              eff_lim;
  logic [UW-1:0]              eff_ent;
  logic [HW-1:0]              n_cnt;
  logic [pswl_pkg::AddrW-1:0] ent_addr;
  logic [HW-1:0]              ent_slot;
  logic [HW-1:0]              ent_hw;
  logic                       hit;
  logic                       search_more;
  logic                       count_more;
  logic                       refuse;
  logic                       room;
  logic [HW-1:0]              wslot;
  logic [HW-1:0]              wslot_n;
  logic [HW-1:0]              new_hw;
  logic                       take_disabled;
  logic                       out_refused;

  // limits saturate at the sizes of the stores
  always_comb begin
    if (32'(cfg_i.req_limit) > 32'(MAX_STAMPS)) begin
      eff_lim = HW'(MAX_STAMPS);
    end else begin
      eff_lim = HW'(cfg_i.req_limit);
    end
    if (32'(cfg_i.cli_limit) > 32'(MAX_ENTRIES)) begin
      eff_ent = UW'(MAX_ENTRIES);
    end else begin
      eff_ent = UW'(cfg_i.cli_limit);
    end
  end

  assign ent_addr = ent_rdata_i[EW-1 -: pswl_pkg::AddrW];
  assign ent_slot = ent_rdata_i[2*HW-1:HW];
  assign ent_hw   = ent_rdata_i[HW-1:0];

  // written slots always form a prefix of the ring, so only the first hw_q can count
  assign n_cnt       = (hw_q < eff_lim) ? hw_q : eff_lim;
  assign search_more = (ridx_q < used_q);
  assign count_more  = (cidx_q < n_cnt);
  assign hit         = (state_q == ST_SEARCH) && rv_q && alu_eq_i;
  assign refuse      = (cnt_q >= eff_lim);
  assign room        = (used_q < eff_ent);
  assign wslot       = (slot_q >= eff_lim) ? '0 : slot_q;
  assign wslot_n     = wslot + HW'(1);
  assign new_hw      = (wslot_n > hw_q) ? wslot_n : hw_q;

  always_comb begin
    if (state_q == ST_SEARCH) begin
      alu_a_o = addr_q;
      alu_b_o = ent_addr;
    end else begin
      alu_a_o = now_q;
      alu_b_o = stp_rdata_i;
    end
  end

  always_comb begin
    mem_ctl_o        = '0;
    mem_ctl_o.ent_re = (state_q == ST_SEARCH) && !hit && search_more;
    mem_ctl_o.stp_re = (state_q == ST_COUNT) && count_more;
    ent_raddr_o      = ridx_q[EIW-1:0];
    stp_raddr_o      = {hit_idx_q, cidx_q[SIW-1:0]};
    ent_waddr_o      = hit_idx_q;
    ent_wdata_o      = {addr_q, wslot_n, new_hw};
    stp_waddr_o      = {hit_idx_q, wslot[SIW-1:0]};
    stp_wdata_o      = now_q;
    if (state_q == ST_DECIDE && !refuse) begin
      mem_ctl_o.ent_we = 1'b1;
      mem_ctl_o.stp_we = 1'b1;
    end
    if (state_q == ST_CREATE) begin
      ent_waddr_o = used_q[EIW-1:0];
      ent_wdata_o = {addr_q, HW'(1), HW'(1)};
      stp_waddr_o = {used_q[EIW-1:0], SIW'(0)};
      if (room) begin
        mem_ctl_o.ent_we = 1'b1;
        mem_ctl_o.stp_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      now_q       <= '0;
      ridx_q      <= '0;
      pidx_q      <= '0;
      rv_q        <= 1'b0;
      hit_idx_q   <= '0;
      slot_q      <= '0;
      hw_q        <= '0;
      cidx_q      <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      res_lim_q   <= 1'b0;
      res_code_q  <= pswl_pkg::OUT_ALLOWED;
      out_valid_q <= 1'b0;
      out_lim_q   <= 1'b0;
      out_code_q  <= pswl_pkg::OUT_ALLOWED;
    end else begin
      // in done a taken result is replaced below
      if (out_valid_q && m_tready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            addr_q <= client_addr_i;
            now_q  <= now_seconds_i;
            ridx_q <= '0;
            rv_q   <= 1'b0;
            if (!cfg_i.enable) begin
              res_lim_q  <= 1'b0;
              res_code_q <= pswl_pkg::OUT_DISABLED;
              state_q    <= ST_DONE;
            end else begin
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // read one entry per cycle, compare the one read the cycle before
          if (hit) begin
            hit_idx_q <= pidx_q;
            slot_q    <= ent_slot;
            hw_q      <= ent_hw;
            cidx_q    <= '0;
            cnt_q     <= '0;
            rv_q      <= 1'b0;
            state_q   <= ST_COUNT;
          end else if (search_more) begin
            pidx_q <= ridx_q[EIW-1:0];
            ridx_q <= ridx_q + UW'(1);
            rv_q   <= 1'b1;
          end else begin
            rv_q    <= 1'b0;
            state_q <= ST_CREATE;
          end
        end
        ST_COUNT: begin
          if (rv_q && alu_young_i) begin
            cnt_q <= cnt_q + HW'(1);
          end
          if (count_more) begin
            cidx_q <= cidx_q + HW'(1);
            rv_q   <= 1'b1;
          end else begin
            rv_q    <= 1'b0;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (refuse) begin
            res_lim_q  <= 1'b1;
            res_code_q <= pswl_pkg::OUT_REFUSED;
          end else begin
            res_lim_q  <= 1'b0;
            res_code_q <= pswl_pkg::OUT_ALLOWED;
          end
          state_q <= ST_DONE;
        end
        ST_CREATE: begin
          res_lim_q <= 1'b0;
          if (room) begin
            used_q     <= used_q + UW'(1);
            res_code_q <= pswl_pkg::OUT_NEW_ENTRY;
          end else begin
            res_code_q <= pswl_pkg::OUT_TABLE_FULL;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_tready_i) begin
            out_valid_q <= 1'b1;
            out_lim_q   <= res_lim_q;
            out_code_q  <= res_code_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign limited_o  = out_lim_q;
  assign outcome_o  = out_code_q;

  assign take_disabled = (state_q == ST_IDLE) && s_tvalid_i && !cfg_i.enable;
  assign out_refused   = (out_code_q == pswl_pkg::OUT_REFUSED);

  `ASSERT_HOLDS(a_used_bound, 1'b1, used_q <= UW'(MAX_ENTRIES))
  `ASSERT_HOLDS(a_lim_only_refused, out_valid_q, out_lim_q == out_refused)
  `ASSERT_NEXT(a_disabled_direct, take_disabled, state_q == ST_DONE && res_code_q == pswl_pkg::OUT_DISABLED)
  `ASSERT_NEXT(a_full_keeps_used, state_q == ST_CREATE && !room, used_q == $past(used_q))
  `ASSERT_HOLDS(a_write_states, mem_ctl_o.ent_we, state_q == ST_DECIDE || state_q == ST_CREATE)

endmodule

[src/per_client_sliding_window_limiter_core.sv]
// with limiting off an accepted item goes straight to the done state; with limiting on it
// goes through search, then count and decide (known client) or create (new client), then
// done, with one entry memory read per client searched and one stamp read per stamp counted
// throughput: one item at a time; the next item is taken the cycle after a result is loaded,
// and a result still waiting on m_axis_tready holds the next one back
// reset: enable 1, window 60 s, request limit 10, client limit 64, client table empty
module per_client_sliding_window_limiter_core #(
  parameter int unsigned MAX_ENTRIES = pswl_pkg::MaxEntries,
  parameter int unsigned MAX_STAMPS  = pswl_pkg::MaxStamps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // client_addr [31:0], now_seconds [63:32]
  input  logic [pswl_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // limited [0], outcome [3:1], zero [7:4]
  output logic [pswl_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pswl_pkg::PaddrW-1:0]   paddr,
  input  logic [pswl_pkg::PdataW-1:0]   pwdata,
  output logic [pswl_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned SIW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int unsigned HW  = $clog2(MAX_STAMPS + 1);
  localparam int unsigned EW  = pswl_pkg::AddrW + 2 * HW;
  localparam int unsigned STW = EIW + SIW;
  localparam int unsigned PadW = pswl_pkg::OutDataW - 1 - pswl_pkg::OutcomeW;

  pswl_pkg::cfg_t             cfg_q;
  pswl_pkg::reg_idx_e         reg_idx;
  pswl_pkg::mem_ctl_t         mem_ctl;
  pswl_pkg::outcome_e         outcome;
  logic                       limited;
  logic [EIW-1:0]             ent_raddr;
  logic [EIW-1:0]             ent_waddr;
  logic [EW-1:0]              ent_wdata;
  logic [EW-1:0]              ent_rdata;
  logic [STW-1:0]             stp_raddr;
  logic [STW-1:0]             stp_waddr;
  logic [pswl_pkg::TimeW-1:0] stp_wdata;
  logic [pswl_pkg::TimeW-1:0] stp_rdata;
  logic [pswl_pkg::AddrW-1:0] alu_a;
  logic [pswl_pkg::AddrW-1:0] alu_b;
  logic                       alu_eq;
  logic                       alu_young;

  assign pready  = 1'b1;
  assign reg_idx = pswl_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= pswl_pkg::EnableRst;
      cfg_q.window    <= pswl_pkg::WindowRst;
      cfg_q.req_limit <= pswl_pkg::ReqLimRst;
      cfg_q.cli_limit <= pswl_pkg::CliLimRst;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        pswl_pkg::REG_ENABLE:    cfg_q.enable    <= pwdata[0];
        pswl_pkg::REG_WINDOW:    cfg_q.window    <= pwdata[pswl_pkg::WinW-1:0];
        pswl_pkg::REG_REQ_LIMIT: cfg_q.req_limit <= pwdata[pswl_pkg::ReqLimW-1:0];
        pswl_pkg::REG_CLI_LIMIT: cfg_q.cli_limit <= pwdata[pswl_pkg::CliLimW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pswl_pkg::REG_ENABLE:    prdata = pswl_pkg::PdataW'(cfg_q.enable);
      pswl_pkg::REG_WINDOW:    prdata = pswl_pkg::PdataW'(cfg_q.window);
      pswl_pkg::REG_REQ_LIMIT: prdata = pswl_pkg::PdataW'(cfg_q.req_limit);
      pswl_pkg::REG_CLI_LIMIT: prdata = pswl_pkg::PdataW'(cfg_q.cli_limit);
      default:                 prdata = '0;
    endcase
  end

  pswl_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .window_i (cfg_q.window),
    .eq_o     (alu_eq),
    .young_o  (alu_young)
  );

  pswl_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_STAMPS  (MAX_STAMPS)
  ) u_store (
    .clk_i       (clk_i),
    .mem_ctl_i   (mem_ctl),
    .ent_raddr_i (ent_raddr),
    .ent_waddr_i (ent_waddr),
    .ent_wdata_i (ent_wdata),
    .ent_rdata_o (ent_rdata),
    .stp_raddr_i (stp_raddr),
    .stp_waddr_i (stp_waddr),
    .stp_wdata_i (stp_wdata),
    .stp_rdata_o (stp_rdata)
  );

  pswl_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_STAMPS  (MAX_STAMPS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_o    (s_axis_tready),
    .client_addr_i (s_axis_tdata[pswl_pkg::AddrW-1:0]),
    .now_seconds_i (s_axis_tdata[pswl_pkg::InDataW-1:pswl_pkg::AddrW]),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .limited_o     (limited),
    .outcome_o     (outcome),
    .mem_ctl_o     (mem_ctl),
    .ent_raddr_o   (ent_raddr),
    .ent_waddr_o   (ent_waddr),
    .ent_wdata_o   (ent_wdata),
    .ent_rdata_i   (ent_rdata),
    .stp_raddr_o   (stp_raddr),
    .stp_waddr_o   (stp_waddr),
    .stp_wdata_o   (stp_wdata),
    .stp_rdata_i   (stp_rdata),
    .alu_a_o       (alu_a),
    .alu_b_o       (alu_b),
    .alu_eq_i      (alu_eq),
    .alu_young_i   (alu_young)
  );

  assign m_axis_tdata = {{PadW{1'b0}}, pswl_pkg::OutcomeW'(outcome), limited};

endmodule
